// ----- rtl/fwgc_pkg.sv -----
`default_nettype none
package fwgc_pkg;

    // The window length register is six bits wide whatever the cell count.
    localparam int WIN_W          = 6;
    localparam int POS_W          = 32;
    localparam int MAX_WINDOW_DEF = 63;

    localparam logic [7:0] CH_HEADER  = 8'h3E; // '>'
    localparam logic [7:0] CH_NEWLINE = 8'h0A; // '\n'
    localparam logic [7:0] CH_UP_G    = 8'h47;
    localparam logic [7:0] CH_UP_C    = 8'h43;
    localparam logic [7:0] CH_LO_G    = 8'h67;
    localparam logic [7:0] CH_LO_C    = 8'h63;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_T    = 8'h54;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_T    = 8'h74;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(32);

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_stream;
    } in_beat_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [WIN_W-1:0] gc_count;
        logic             has_n;
        logic             last;
    } out_beat_t;

    // Control broadcast to every cell of the pending-window chain.
    typedef struct packed {
        logic take;   // a base is being counted this cycle
        logic is_gc;  // the base is G or C
        logic is_at;  // the base is A or T
        logic shift;  // move every entry one cell further down the chain
        logic clear;  // drop all pending windows
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/fwgc_cell.sv -----
`default_nettype none
module fwgc_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire fwgc_pkg::cell_ctrl_t      ctrl,
    input  wire logic                      in_win,
    input  wire logic [fwgc_pkg::WIN_W-1:0] prev_gc,
    input  wire logic                      prev_n,
    output logic      [fwgc_pkg::WIN_W-1:0] upd_gc,
    output logic                           upd_n
);
    import fwgc_pkg::*;

    logic [WIN_W-1:0] gc_reg, gc_next;
    logic             n_reg, n_next;

    // Value of this window after the current base, before the shift.
    always_comb begin
        upd_gc = gc_reg;
        upd_n  = n_reg;
        if (ctrl.take && in_win) begin
            if (ctrl.is_gc) begin
                if (!n_reg) begin
                    upd_gc = gc_reg + WIN_W'(1);
                end
            end else if (!ctrl.is_at) begin
                upd_n  = 1'b1;
                upd_gc = '0;
            end
        end
    end

    always_comb begin
        gc_next = gc_reg;
        n_next  = n_reg;
        if (ctrl.clear) begin
            gc_next = '0;
            n_next  = 1'b0;
        end else if (ctrl.shift) begin
            gc_next = prev_gc;
            n_next  = prev_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gc_reg <= '0;
            n_reg  <= 1'b0;
        end else begin
            gc_reg <= gc_next;
            n_reg  <= n_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/fasta_window_gc_counter.sv -----
`default_nettype none
// Sliding-window GC counter for FASTA text.
// Text arrives on the s_ channel, one byte per beat, with end_of_stream marking
// the end of a file. Results leave on the m_ channel: a base position, the
// number of G/C bases among the following window_len bases, an N flag and a
// last flag. The window length is written through the cfg_ channel, which is
// always ready; write it only while the block is idle.
// A result appears in the output register in the cycle after the base that
// completes its window is taken, so a stream of bases runs at one beat per
// cycle as long as the receiver keeps up. A second '>' or an end beat in the
// sequence body, with windows pending, starts a flush that walks the chain of
// cells once per cycle while the receiver keeps up, and the pending positions
// come out oldest first with the final one flagged.
// While flushing, s_ready is low. When the receiver stalls, the result holds
// in the output register and no new byte is taken until it is gone.
// Reset clears the parser, the base counter and every pending window, and sets
// the window length to 32. An end beat clears the same state but keeps the
// window length.
module fasta_window_gc_counter #(
    parameter int MAX_WINDOW = fwgc_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire fwgc_pkg::in_beat_t         s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output fwgc_pkg::out_beat_t             m_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [fwgc_pkg::WIN_W-1:0] cfg_data
);
    import fwgc_pkg::*;

    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam logic [WIN_W-1:0]  MAX_W    = WIN_W'(MAX_WINDOW);
    localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_WINDOW);

    // Architectural state.
    logic [WIN_W-1:0]  window_len_reg, window_len_next;
    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  base_count_reg, base_count_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // Flush sequencer.
    logic              flushing_reg, flushing_next;
    logic              flush_end_reg, flush_end_next;
    logic [WIN_W-1:0]  flush_cnt_reg, flush_cnt_next;
    logic [POS_W-1:0]  flush_pos_reg, flush_pos_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_data_reg, m_data_next;

    // Chain of pending windows; cell k belongs to position base_count-1-k.
    cell_ctrl_t        ctrl;
    logic [WIN_W-1:0]  cell_upd_gc [MAX_WINDOW];
    logic              cell_upd_n  [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] cell_in_win;

    logic [WIN_W-1:0]  win_eff;
    logic [WIN_W-1:0]  fill_ext;
    logic [WIN_W-1:0]  pend_cnt;
    logic [WIN_W-1:0]  tap_gc;
    logic              tap_n;
    logic              out_free;
    logic              accept;
    logic              is_letter, is_gc, is_at;
    logic              flush_emit;
    logic              flush_step;
    logic              flush_done;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
            logic [WIN_W-1:0] prev_gc;
            logic             prev_n;
            if (gi == 0) begin : g_head
                assign prev_gc = '0;
                assign prev_n  = 1'b0;
            end else begin : g_link
                assign prev_gc = cell_upd_gc[gi-1];
                assign prev_n  = cell_upd_n[gi-1];
            end
            assign cell_in_win[gi] = (WIN_W'(gi) < pend_cnt);
            fwgc_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .in_win  (cell_in_win[gi]),
                .prev_gc (prev_gc),
                .prev_n  (prev_n),
                .upd_gc  (cell_upd_gc[gi]),
                .upd_n   (cell_upd_n[gi])
            );
        end
    endgenerate

    // Window length as used, and the number of windows still pending.
    always_comb begin
        win_eff  = (window_len_reg > MAX_W) ? MAX_W : window_len_reg;
        fill_ext = WIN_W'(fill_reg);
        pend_cnt = (fill_ext < win_eff) ? fill_ext : win_eff;
    end

    // The tap is the cell whose window is complete: index win_eff - 1.
    always_comb begin
        tap_gc = '0;
        tap_n  = 1'b0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            if (WIN_W'(k) == win_eff - WIN_W'(1)) begin
                tap_gc = cell_upd_gc[k];
                tap_n  = cell_upd_n[k];
            end
        end
    end

    always_comb begin
        is_letter = (s_data.text_byte inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]});
        is_gc     = (s_data.text_byte inside {CH_UP_G, CH_UP_C, CH_LO_G, CH_LO_C});
        is_at     = (s_data.text_byte inside {CH_UP_A, CH_UP_T, CH_LO_A, CH_LO_T});
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !flushing_reg && out_free;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // During a flush the chain shifts toward the tap; the first
    // window_len - pending shifts carry nothing and emit nothing.
    assign flush_emit = flushing_reg && (flush_cnt_reg >= (win_eff - pend_cnt));
    assign flush_step = flushing_reg && (!flush_emit || out_free);
    assign flush_done = flush_step && (flush_cnt_reg == win_eff - WIN_W'(1));

    always_comb begin
        window_len_next = window_len_reg;
        phase_next      = phase_reg;
        base_count_next = base_count_reg;
        fill_next       = fill_reg;
        flushing_next   = flushing_reg;
        flush_end_next  = flush_end_reg;
        flush_cnt_next  = flush_cnt_reg;
        flush_pos_next  = flush_pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        ctrl       = '0;
        ctrl.is_gc = is_gc;
        ctrl.is_at = is_at;

        if (cfg_valid && cfg_ready) begin
            window_len_next = cfg_data;
        end

        if (accept) begin
            if (s_data.end_of_stream) begin
                if (phase_reg == PH_BODY && pend_cnt != '0) begin
                    flushing_next  = 1'b1;
                    flush_end_next = 1'b1;
                    flush_cnt_next = '0;
                    flush_pos_next = base_count_reg - POS_W'(pend_cnt);
                    phase_next     = PH_SEARCH;
                end else begin
                    phase_next      = PH_SEARCH;
                    base_count_next = '0;
                    fill_next       = '0;
                    ctrl.clear      = 1'b1;
                end
            end else begin
                case (phase_reg)
                    PH_SEARCH: begin
                        if (s_data.text_byte == CH_HEADER) begin
                            phase_next = PH_HEADER;
                        end
                    end
                    PH_HEADER: begin
                        if (s_data.text_byte == CH_NEWLINE) begin
                            phase_next = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (s_data.text_byte == CH_HEADER) begin
                            phase_next = PH_DONE;
                            if (pend_cnt != '0) begin
                                flushing_next  = 1'b1;
                                flush_end_next = 1'b0;
                                flush_cnt_next = '0;
                                flush_pos_next = base_count_reg - POS_W'(pend_cnt);
                            end
                        end else if (is_letter) begin
                            ctrl.take  = 1'b1;
                            ctrl.shift = 1'b1;
                            base_count_next = base_count_reg + POS_W'(1);
                            if (fill_reg < MAX_FILL) begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                            if (win_eff == '0) begin
                                m_valid_next         = 1'b1;
                                m_data_next.position = base_count_reg;
                                m_data_next.gc_count = '0;
                                m_data_next.has_n    = 1'b0;
                                m_data_next.last     = 1'b1;
                            end else if (fill_ext >= win_eff) begin
                                m_valid_next         = 1'b1;
                                m_data_next.position = base_count_reg - POS_W'(win_eff);
                                m_data_next.gc_count = tap_n ? '0 : tap_gc;
                                m_data_next.has_n    = tap_n;
                                m_data_next.last     = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (flush_step) begin
            ctrl.shift     = 1'b1;
            flush_cnt_next = flush_cnt_reg + WIN_W'(1);
            if (flush_emit) begin
                m_valid_next         = 1'b1;
                m_data_next.position = flush_pos_reg;
                m_data_next.gc_count = tap_n ? '0 : tap_gc;
                m_data_next.has_n    = tap_n;
                m_data_next.last     = flush_done;
                flush_pos_next       = flush_pos_reg + POS_W'(1);
            end
            if (flush_done) begin
                flushing_next = 1'b0;
                if (flush_end_reg) begin
                    base_count_next = '0;
                    fill_next       = '0;
                    ctrl.clear      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_RESET;
            phase_reg      <= PH_SEARCH;
            base_count_reg <= '0;
            fill_reg       <= '0;
            flushing_reg   <= 1'b0;
            flush_end_reg  <= 1'b0;
            flush_cnt_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            window_len_reg <= window_len_next;
            phase_reg      <= phase_next;
            base_count_reg <= base_count_next;
            fill_reg       <= fill_next;
            flushing_reg   <= flushing_next;
            flush_end_reg  <= flush_end_next;
            flush_cnt_reg  <= flush_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        flush_pos_reg <= flush_pos_next;
        m_data_reg    <= m_data_next;
    end

endmodule
`default_nettype wire

// ----- tb/tb_fasta_window_gc_counter.sv -----
`default_nettype none
// Self-checking bench for the sliding-window GC counter.
//
// An initial block builds the FASTA text as a queue of input beats. A clocked
// driver offers those beats on the s_ channel, and each accepted beat is run
// through a bit-accurate software copy of the counter, which pushes the results
// it predicts onto a queue. A clocked monitor drains the m_ channel and checks
// every result beat, field by field, against the oldest prediction.
module tb_fasta_window_gc_counter;
    import fwgc_pkg::*;

    localparam int          MAX_WIN    = MAX_WINDOW_DEF;
    // Cycles to let pass once nothing is predicted any more, so that the
    // block is surely idle before the window length changes.
    localparam int          SETTLE     = MAX_WIN + 17;
    localparam int          CYCLE_CAP  = 200000;
    localparam int          RAND_BEATS = 80;

    // A few more characters that the directed text uses.
    localparam logic [7:0]  CH_UP_N    = 8'h4E;
    localparam logic [7:0]  CH_UP_Q    = 8'h51;
    localparam logic [7:0]  CH_DIGIT_1 = 8'h31;
    localparam logic [7:0]  CH_SPACE   = 8'h20;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_beat_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_beat_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [WIN_W-1:0]       cfg_data  = '0;

    fasta_window_gc_counter #(
        .MAX_WINDOW(MAX_WIN)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Text beats waiting to be offered, and count results still owed.
    in_beat_t               text_beats_todo[$];
    out_beat_t              gc_results_due[$];

    int                     mismatches    = 0;
    int                     beats_in      = 0;
    int                     results_seen  = 0;
    int                     beats_queued  = 0;
    int                     cycle_count   = 0;
    bit                     gen_in_body   = 1'b0;

    // Software copy of the counter state. Entry k of the pending arrays
    // belongs to base position base_cnt - 1 - k.
    logic [WIN_W-1:0]       win_len;
    phase_t                 phase;
    logic [POS_W-1:0]       base_cnt;
    logic [WIN_W-1:0]       pend_gc[MAX_WIN];
    bit                     pend_n[MAX_WIN];
    int unsigned            fill;

    logic [7:0]             bases[8] = '{CH_UP_A, CH_UP_C, CH_UP_G, CH_UP_T,
                                         CH_LO_A, CH_LO_C, CH_LO_G, CH_LO_T};

    // ------------------------------------------------------------------
    // Counter model
    // ------------------------------------------------------------------

    // Drops the parser and every pending window; the window length stays.
    task automatic clear_windows();
        phase    = PH_SEARCH;
        base_cnt = '0;
        fill     = 0;
        for (int k = 0; k < MAX_WIN; k++) begin
            pend_gc[k] = '0;
            pend_n[k]  = 1'b0;
        end
    endtask

    // The window length in use: the register clamped to the cell count.
    function automatic int unsigned window_span();
        int unsigned w;
        w = win_len;
        if (w > MAX_WIN) w = MAX_WIN;
        return w;
    endfunction

    task automatic owe_count(input logic [POS_W-1:0] pos, input logic [WIN_W-1:0] gc,
                             input bit n, input bit lst);
        out_beat_t r;
        r.position = pos;
        r.gc_count = n ? '0 : gc;
        r.has_n    = n;
        r.last     = lst;
        gc_results_due.insert(gc_results_due.size(), r);
    endtask

    // Emits the pending positions, oldest first, with partial windows.
    task automatic flush_windows();
        int unsigned w, m, k;
        w = window_span();
        m = (fill < w) ? fill : w;
        k = m;
        while (k > 0) begin
            k--;
            owe_count(base_cnt - 1 - POS_W'(k), pend_gc[k], pend_n[k], k == 0);
        end
    endtask

    // Adds one base to every open window and retires the one it completes.
    task automatic count_base(input logic [7:0] c);
        int unsigned w, m;
        bit          is_gc, is_at;
        w     = window_span();
        m     = (fill < w) ? fill : w;
        is_gc = (c == CH_UP_G) || (c == CH_UP_C) || (c == CH_LO_G) || (c == CH_LO_C);
        is_at = (c == CH_UP_A) || (c == CH_UP_T) || (c == CH_LO_A) || (c == CH_LO_T);
        for (int k = 0; k < m; k++) begin
            if (is_gc) begin
                if (!pend_n[k]) pend_gc[k] = pend_gc[k] + 1'b1;
            end else if (!is_at) begin
                pend_n[k]  = 1'b1;
                pend_gc[k] = '0;
            end
        end
        if (w == 0) begin
            owe_count(base_cnt, '0, 1'b0, 1'b1);
        end else if (fill >= w) begin
            owe_count(base_cnt - POS_W'(w), pend_gc[w-1], pend_n[w-1], 1'b1);
        end
        for (int k = MAX_WIN - 1; k > 0; k--) begin
            pend_gc[k] = pend_gc[k-1];
            pend_n[k]  = pend_n[k-1];
        end
        pend_gc[0] = '0;
        pend_n[0]  = 1'b0;
        base_cnt   = base_cnt + 1'b1;
        if (fill < MAX_WIN) fill++;
    endtask

    // Runs one accepted text beat through the model.
    task automatic gc_window_predict(input in_beat_t b);
        logic [7:0] c;
        bit         letter;
        c      = b.text_byte;
        letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
        if (b.end_of_stream) begin
            if (phase == PH_BODY) flush_windows();
            clear_windows();
        end else begin
            case (phase)
                PH_SEARCH: begin
                    if (c == CH_HEADER) phase = PH_HEADER;
                end
                PH_HEADER: begin
                    if (c == CH_NEWLINE) phase = PH_BODY;
                end
                PH_BODY: begin
                    if (c == CH_HEADER) begin
                        flush_windows();
                        phase = PH_DONE;
                    end else if (letter) begin
                        count_base(c);
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued text beats. Valid rises without looking at
    // ready and then holds, payload fixed, until the beat is taken. About
    // one free cycle in ten stays empty, except during a quiet stretch.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            gc_window_predict(s_data);
            beats_in++;
        end
        if (!s_valid || s_ready) begin
            if (aresetn && (text_beats_todo.size() > 0) &&
                (((beats_in >= 40) && (beats_in < 80)) || ($urandom_range(0, 99) >= 10))) begin
                s_data  <= text_beats_todo.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result beat against the oldest prediction.
    // Ready drops in about one cycle in ten, again with a quiet stretch.
    // ------------------------------------------------------------------
    task automatic check_result(input out_beat_t got);
        out_beat_t want;
        if (gc_results_due.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result: pos=%0d gc=%0d n=%0b last=%0b",
                         got.position, got.gc_count, got.has_n, got.last);
            mismatches++;
        end else begin
            want = gc_results_due.pop_front();
            if ((got.position !== want.position) || (got.gc_count !== want.gc_count) ||
                (got.has_n !== want.has_n) || (got.last !== want.last)) begin
                if (mismatches < 10)
                    $display("result %0d: expected pos=%0d gc=%0d n=%0b last=%0b, got pos=%0d gc=%0d n=%0b last=%0b",
                             results_seen, want.position, want.gc_count, want.has_n,
                             want.last, got.position, got.gc_count, got.has_n, got.last);
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            check_result(m_data);
            results_seen++;
        end
        m_ready <= ((results_seen >= 40) && (results_seen < 100)) ||
                   ($urandom_range(0, 99) >= 10);
    end

    // A hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_beat(input logic [7:0] ch, input bit eos);
        in_beat_t b;
        b.text_byte     = ch;
        b.end_of_stream = eos;
        text_beats_todo.insert(text_beats_todo.size(), b);
        beats_queued++;
    endtask

    function automatic logic [7:0] byte_other_than(input logic [7:0] ban);
        logic [7:0] r;
        do r = 8'($urandom_range(0, 255)); while (r == ban);
        return r;
    endfunction

    // Waits until every beat is taken and every result has come, then lets
    // the block settle before anything else happens.
    task automatic drain();
        while ((text_beats_todo.size() != 0) || s_valid || (gc_results_due.size() != 0))
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Writes the window length. Only called once the block has drained.
    task automatic set_window(input logic [WIN_W-1:0] len);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_len    = len;
    endtask

    // Sequence body: mostly ACGT in both cases, with other letters, line
    // breaks and raw noise (never a '>', which the caller places itself).
    task automatic gen_body(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                queue_beat(bases[$urandom_range(0, 7)], 1'b0);
            else if (r < 66)
                queue_beat($urandom_range(0, 1) ? 8'($urandom_range(CH_UP_A, CH_UP_Z))
                                                : 8'($urandom_range(CH_LO_A, CH_LO_Z)), 1'b0);
            else if (r < 76)
                queue_beat(CH_NEWLINE, 1'b0);
            else
                queue_beat(byte_other_than(CH_HEADER), 1'b0);
        end
    endtask

    // One record. close_kind 0 leaves the body open for the next phase,
    // 1 ends the file, 2 closes with a second '>' and trailing junk, then ends it.
    // Now and then the file is cut short inside the header.
    task automatic gen_record(input int n, input int close_kind);
        int hdr;
        bit cut;
        cut = 1'b0;
        if (!gen_in_body) begin
            repeat ($urandom_range(0, 2)) queue_beat(byte_other_than(CH_HEADER), 1'b0);
            queue_beat(CH_HEADER, 1'b0);
            hdr = $urandom_range(0, 4);
            repeat (hdr) queue_beat(byte_other_than(CH_NEWLINE), 1'b0);
            if ($urandom_range(0, 9) == 0) begin
                queue_beat(8'($urandom_range(0, 255)), 1'b1);
                cut = 1'b1;
            end else begin
                queue_beat(CH_NEWLINE, 1'b0);
                gen_in_body = 1'b1;
            end
        end
        if (!cut) begin
            gen_body(n);
            if (close_kind == 2) begin
                queue_beat(CH_HEADER, 1'b0);
                repeat ($urandom_range(0, 3)) queue_beat(8'($urandom_range(0, 255)), 1'b0);
            end
            if (close_kind != 0) begin
                queue_beat(8'($urandom_range(0, 255)), 1'b1);
                gen_in_body = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int start_count;
        int phase_no;
        int pick;
        logic [WIN_W-1:0] len;

        win_len = WINDOW_RESET;
        clear_windows();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset window length of 32. An end beat while searching emits
        // nothing; a '>' inside the header is just header text. The body
        // mixes both cases, an N, other letters, a high byte, a digit and
        // a line break, and the end beat flushes eight partial windows.
        queue_beat(8'hFF, 1'b1);
        queue_beat(CH_HEADER, 1'b0);
        queue_beat(8'h00, 1'b0);
        queue_beat(CH_HEADER, 1'b0);
        queue_beat(CH_NEWLINE, 1'b0);
        queue_beat(CH_UP_G, 1'b0);
        queue_beat(CH_LO_C, 1'b0);
        queue_beat(CH_LO_A, 1'b0);
        queue_beat(CH_UP_T, 1'b0);
        queue_beat(CH_UP_N, 1'b0);
        queue_beat(8'hFF, 1'b0);
        queue_beat(CH_DIGIT_1, 1'b0);
        queue_beat(CH_NEWLINE, 1'b0);
        queue_beat(CH_LO_G, 1'b0);
        queue_beat(CH_UP_C, 1'b0);
        queue_beat(CH_LO_Z, 1'b0);
        queue_beat(8'h80, 1'b0);
        queue_beat(CH_SPACE, 1'b1);
        drain();

        // Shortest window: every base but the first retires a count, and
        // a second '>' flushes the last one. Bytes after it are ignored and
        // the end beat in that state emits nothing.
        set_window(WIN_W'(1));
        queue_beat(CH_HEADER, 1'b0);
        queue_beat(CH_NEWLINE, 1'b0);
        queue_beat(CH_UP_A, 1'b0);
        queue_beat(CH_UP_G, 1'b0);
        queue_beat(CH_UP_C, 1'b0);
        queue_beat(CH_HEADER, 1'b0);
        queue_beat(CH_UP_Q, 1'b0);
        queue_beat(8'h7F, 1'b1);
        drain();

        // Zero window: each base answers for itself at once, flush is empty.
        set_window(WIN_W'(0));
        queue_beat(CH_HEADER, 1'b0);
        queue_beat(CH_NEWLINE, 1'b0);
        queue_beat(CH_UP_G, 1'b0);
        queue_beat(CH_LO_T, 1'b0);
        queue_beat(8'h01, 1'b1);
        drain();

        // Random records. The first phase uses the widest window and leaves
        // its body open, so the next write changes the length mid-stream.
        start_count = beats_queued;
        phase_no    = 0;
        while (beats_queued - start_count < RAND_BEATS) begin
            pick = $urandom_range(0, 9);
            if (phase_no == 0)      len = WIN_W'(MAX_WIN);
            else if (phase_no == 1) len = WIN_W'($urandom_range(2, 6));
            else if (pick == 0)     len = '0;
            else if (pick == 1)     len = WIN_W'(1);
            else if (pick == 2)     len = WIN_W'(MAX_WIN);
            else if (pick == 3)     len = WIN_W'($urandom_range(1, MAX_WIN));
            else                    len = WIN_W'($urandom_range(2, 6));
            set_window(len);
            gen_record($urandom_range(5, 30), (phase_no == 0) ? 0 : $urandom_range(0, 2));
            drain();
            phase_no++;
        end
        if (gen_in_body) gen_record(4, 1);
        drain();

        // Any prediction still waiting is a result that never came.
        mismatches += gc_results_due.size();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/fwgc_pkg.sv
rtl/fwgc_cell.sv
rtl/fasta_window_gc_counter.sv
tb/tb_fasta_window_gc_counter.sv
